@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the ADC configuration write sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is high.
`define ACWS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ACWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/acws_pkg.sv @@
// Shared types, codes and constants of the ADC configuration write sequencer.
`default_nettype none

package acws_pkg;

  // Request types.
  localparam logic [1:0] REQ_LVDS = 2'd0;
  localparam logic [1:0] REQ_CHAN = 2'd1;
  localparam logic [1:0] REQ_TEST = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Test pattern selections; the two remaining codes act as off.
  localparam logic [2:0] TS_OFF     = 3'd0;
  localparam logic [2:0] TS_COUNTER = 3'd1;
  localparam logic [2:0] TS_ALT     = 3'd2;
  localparam logic [2:0] TS_SINGLE  = 3'd3;
  localparam logic [2:0] TS_DESKEW  = 3'd4;
  localparam logic [2:0] TS_SYNC    = 3'd5;

  // Configuration register indexes and port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [8:0]        RST_DRIVE = 9'd219;
  localparam logic [8:0]        RST_TERM  = 9'd0;
  localparam logic signed [1:0] RST_ADV   = 2'sd0;
  localparam logic [1:0]        RST_PHASE = 2'd0;
  localparam logic [15:0]       RST_CHAN  = 16'h8888;

  // Advance/delay settings.
  localparam logic signed [1:0] AD_ADVANCE = -2'sd1;
  localparam logic signed [1:0] AD_DELAY   = 2'sd1;

  // ADC register addresses.
  localparam logic [7:0] ADDR_DRIVE   = 8'h11;
  localparam logic [7:0] ADDR_TERM    = 8'h12;
  localparam logic [7:0] ADDR_ADV     = 8'h53;
  localparam logic [7:0] ADDR_PHASE   = 8'h42;
  localparam logic [7:0] ADDR_CHAN_A  = 8'h3a;
  localparam logic [7:0] ADDR_CHAN_B  = 8'h3b;
  localparam logic [7:0] ADDR_TEST_25 = 8'h25;
  localparam logic [7:0] ADDR_TEST_26 = 8'h26;
  localparam logic [7:0] ADDR_TEST_27 = 8'h27;
  localparam logic [7:0] ADDR_TEST_45 = 8'h45;

  // Data words.
  localparam logic [15:0] DATA_COUNTER = 16'h0040;
  localparam logic [15:0] DATA_ALT     = 16'h0020;
  localparam logic [15:0] DATA_SINGLE  = 16'h0010;
  localparam logic [15:0] DATA_DESKEW  = 16'h0001;
  localparam logic [15:0] DATA_SYNC    = 16'h0002;
  localparam logic [15:0] DATA_AD_ADV  = 16'h0020;
  localparam logic [15:0] DATA_AD_DLY  = 16'h0010;

  // Write position within a run.
  typedef logic [1:0] beat_t;
  localparam beat_t LAST_BEAT_CHAN = 2'd1;
  localparam beat_t LAST_BEAT_FULL = 2'd3;

  typedef struct packed {
    logic [8:0]        drive_currents;
    logic [8:0]        terminations;
    logic signed [1:0] advance_delay;
    logic [1:0]        lvds_phase_sel;
    logic [15:0]       channel_inputs;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  test_sel;
    logic [15:0] test_word;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [15:0] data;
    logic        last;
  } wr_t;

endpackage

`default_nettype wire

@@ rtl/core/acws_cfg_regs.sv @@
// Configuration register file of the ADC configuration write sequencer.
`default_nettype none

module acws_cfg_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [acws_pkg::CFG_IDX_W-1:0]        wr_index,
  input  wire logic [acws_pkg::CFG_DATA_W-1:0]       wr_data,
  output acws_pkg::cfg_t                             cfg
);

  // Each write lands in the register that its index names; other indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_currents <= acws_pkg::RST_DRIVE;
      cfg.terminations   <= acws_pkg::RST_TERM;
      cfg.advance_delay  <= acws_pkg::RST_ADV;
      cfg.lvds_phase_sel <= acws_pkg::RST_PHASE;
      cfg.channel_inputs <= acws_pkg::RST_CHAN;
    end else if (wr_en) begin
      case (wr_index)
        acws_pkg::CFG_DRIVE: cfg.drive_currents <= wr_data[8:0];
        acws_pkg::CFG_TERM:  cfg.terminations   <= wr_data[8:0];
        acws_pkg::CFG_ADV:   cfg.advance_delay  <= $signed(wr_data[1:0]);
        acws_pkg::CFG_PHASE: cfg.lvds_phase_sel <= wr_data[1:0];
        acws_pkg::CFG_CHAN:  cfg.channel_inputs <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/acws_word_gen.sv @@
// Builds one register write of a run from the held command, the settings and the beat.
`default_nettype none

module acws_word_gen (
  input  wire acws_pkg::cmd_t  cmd,
  input  wire acws_pkg::cfg_t  cfg,
  input  wire acws_pkg::beat_t beat,
  output acws_pkg::wr_t        wr
);

  // A selection with more than one bit set is sent as zero.
  function automatic logic [3:0] one_hot_or_zero(input logic [3:0] v);
    logic [3:0] r;
    r = ((v & (v - 4'd1)) != 4'd0) ? 4'd0 : v;
    return r;
  endfunction

  logic [2:0]  drv_c, drv_f, drv_d;
  logic [2:0]  trm_c, trm_f, trm_d;
  logic        trm_any;
  logic [15:0] lvds_drive, lvds_term, lvds_adv, phase_word;
  logic [3:0]  in0, in1, in2, in3;
  logic [15:0] chan_a, chan_b;
  logic [15:0] t25, t26, t27, t45;

  // LVDS words: drive indices are sent inverted in their low two bits.
  always_comb begin
    drv_c      = cfg.drive_currents[2:0] ^ 3'd3;
    drv_f      = cfg.drive_currents[5:3] ^ 3'd3;
    drv_d      = cfg.drive_currents[8:6] ^ 3'd3;
    trm_c      = cfg.terminations[2:0];
    trm_f      = cfg.terminations[5:3];
    trm_d      = cfg.terminations[8:6];
    trm_any    = (cfg.terminations != 9'd0);
    lvds_drive = {5'd0, drv_d, 1'b0, drv_f, 1'b0, drv_c};
    lvds_term  = {1'b0, trm_any, 3'd0, trm_d, 1'b0, trm_f, 1'b0, trm_c};
    if (cfg.advance_delay == acws_pkg::AD_ADVANCE) begin
      lvds_adv = acws_pkg::DATA_AD_ADV;
    end else if (cfg.advance_delay == acws_pkg::AD_DELAY) begin
      lvds_adv = acws_pkg::DATA_AD_DLY;
    end else begin
      lvds_adv = 16'd0;
    end
    phase_word = {9'd0, cfg.lvds_phase_sel, 5'd0};
  end

  // Channel input words.
  always_comb begin
    in0    = one_hot_or_zero(cfg.channel_inputs[3:0]);
    in1    = one_hot_or_zero(cfg.channel_inputs[7:4]);
    in2    = one_hot_or_zero(cfg.channel_inputs[11:8]);
    in3    = one_hot_or_zero(cfg.channel_inputs[15:12]);
    chan_a = {3'd0, in1, 4'd0, in0, 1'b0};
    chan_b = {3'd0, in3, 4'd0, in2, 1'b0};
  end

  // Test pattern words; unknown selections leave everything at zero.
  always_comb begin
    t25 = 16'd0;
    t26 = 16'd0;
    t27 = 16'd0;
    t45 = 16'd0;
    case (cmd.test_sel)
      acws_pkg::TS_COUNTER: t25 = acws_pkg::DATA_COUNTER;
      acws_pkg::TS_ALT: begin
        t25 = acws_pkg::DATA_ALT;
        t26 = {cmd.test_word[15:8], 8'd0};
        t27 = {cmd.test_word[7:0], 8'd0};
      end
      acws_pkg::TS_SINGLE: begin
        t25 = acws_pkg::DATA_SINGLE;
        t26 = {cmd.test_word[7:0], 8'd0};
      end
      acws_pkg::TS_DESKEW: t45 = acws_pkg::DATA_DESKEW;
      acws_pkg::TS_SYNC:   t45 = acws_pkg::DATA_SYNC;
      default: begin
      end
    endcase
  end

  // Pick the write for this beat of the run.
  always_comb begin
    wr.addr = 8'd0;
    wr.data = 16'd0;
    wr.last = 1'b1;
    case (cmd.req_type)
      acws_pkg::REQ_LVDS: begin
        wr.last = (beat == acws_pkg::LAST_BEAT_FULL);
        case (beat)
          2'd0:    begin wr.addr = acws_pkg::ADDR_DRIVE; wr.data = lvds_drive; end
          2'd1:    begin wr.addr = acws_pkg::ADDR_TERM;  wr.data = lvds_term;  end
          2'd2:    begin wr.addr = acws_pkg::ADDR_ADV;   wr.data = lvds_adv;   end
          default: begin wr.addr = acws_pkg::ADDR_PHASE; wr.data = phase_word; end
        endcase
      end
      acws_pkg::REQ_CHAN: begin
        wr.last = (beat == acws_pkg::LAST_BEAT_CHAN);
        if (beat == 2'd0) begin
          wr.addr = acws_pkg::ADDR_CHAN_A;
          wr.data = chan_a;
        end else begin
          wr.addr = acws_pkg::ADDR_CHAN_B;
          wr.data = chan_b;
        end
      end
      acws_pkg::REQ_TEST: begin
        wr.last = (beat == acws_pkg::LAST_BEAT_FULL);
        case (beat)
          2'd0:    begin wr.addr = acws_pkg::ADDR_TEST_25; wr.data = t25; end
          2'd1:    begin wr.addr = acws_pkg::ADDR_TEST_26; wr.data = t26; end
          2'd2:    begin wr.addr = acws_pkg::ADDR_TEST_27; wr.data = t27; end
          default: begin wr.addr = acws_pkg::ADDR_TEST_45; wr.data = t45; end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/adc_config_write_sequencer_top.sv @@
// Top level of the ADC configuration write sequencer.
//
//   channel   direction  handshake            payload
//   command   in         in_valid / in_stall  req_type, test_sel, test_word
//   write     out        out_valid/out_stall  reg_addr, reg_data, last_write
//   config    in         wr_en                wr_index, wr_data
//
// A command is held in the command register while its run goes out, one write a cycle
// unless the write side stalls. An LVDS or test command has four writes, a channel sync
// command two. The next command is taken in the cycle its predecessor's last write
// enters the output register, so runs follow one another without a gap.
// A command of unknown type is taken and dropped with no writes.
// A stall on the write side holds the output register, and the command side stalls
// until the held run can move on. Reset is synchronous and empties both registers.
`default_nettype none

`include "assert_macros.svh"

module adc_config_write_sequencer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       req_type,
  input  wire logic [2:0]                       test_sel,
  input  wire logic [15:0]                      test_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            reg_addr,
  output logic [15:0]                           reg_data,
  output logic                                  last_write,
  input  wire logic                             wr_en,
  input  wire logic [acws_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [acws_pkg::CFG_DATA_W-1:0]  wr_data
);

  acws_pkg::cfg_t  cfg;
  acws_pkg::cmd_t  cmd;
  acws_pkg::beat_t beat;
  acws_pkg::wr_t   wr;
  logic            cmd_valid;
  logic            load;
  logic            in_take;

  acws_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  acws_word_gen u_gen (
    .cmd  (cmd),
    .cfg  (cfg),
    .beat (beat),
    .wr   (wr)
  );

  // Handshake: a write moves into the output register when it is free or draining.
  always_comb begin
    load     = cmd_valid && (!out_valid || !out_stall);
    in_stall = cmd_valid && !(load && wr.last);
    in_take  = in_valid && !in_stall;
  end

  // Command register control: beat counter and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      beat      <= 2'd0;
    end else if (in_take) begin
      cmd_valid <= (req_type != acws_pkg::REQ_NONE);
      beat      <= 2'd0;
    end else if (load) begin
      cmd_valid <= !wr.last;
      beat      <= beat + 2'd1;
    end
  end

  // Command payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd.req_type  <= req_type;
      cmd.test_sel  <= test_sel;
      cmd.test_word <= test_word;
    end
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      reg_addr   <= wr.addr;
      reg_data   <= wr.data;
      last_write <= wr.last;
    end
  end

  `ACWS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !cmd_valid, "reset left an item in flight")
  `ACWS_ASSERT(a_take_when_done, clk, rst, in_take && cmd_valid |-> load && wr.last, "command taken over an unfinished run")
  `ACWS_ASSERT(a_chan_beats, clk, rst, cmd_valid && cmd.req_type == acws_pkg::REQ_CHAN |-> beat <= acws_pkg::LAST_BEAT_CHAN, "channel sync run overran")
  `ACWS_ASSERT(a_last_addr, clk, rst, out_valid && last_write |-> reg_addr == acws_pkg::ADDR_PHASE || reg_addr == acws_pkg::ADDR_CHAN_B || reg_addr == acws_pkg::ADDR_TEST_45, "last marker on a write that does not end a run")

endmodule

`default_nettype wire

@@ dv/acws_tb_pkg.sv @@
// Write predictor and scoreboard class for the ADC configuration write sequencer testbench.
package acws_tb_pkg;
  import acws_pkg::*;

  // First register index past the last real register; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_CHAN + 3'd1;
  // The one advance/delay pattern that is neither advance, delay nor zero.
  localparam logic signed [1:0] AD_RESERVED = -2'sd2;
  // Drive current indices go out inverted in their two low bits.
  localparam logic [8:0] DRIVE_FLIP = 9'o333;
  // Mismatch lines printed before the rest are only counted.
  localparam int unsigned REPORT_CAP = 200;

  class write_scoreboard;
    cfg_t        shadow;
    wr_t         writes_due[$];
    int unsigned mismatches;
    int unsigned writes_seen;
    int unsigned lvds_cmds;
    int unsigned chan_cmds;
    int unsigned test_cmds;
    int unsigned dropped_cmds;

    function new();
      shadow.drive_currents = RST_DRIVE;
      shadow.terminations   = RST_TERM;
      shadow.advance_delay  = RST_ADV;
      shadow.lvds_phase_sel = RST_PHASE;
      shadow.channel_inputs = RST_CHAN;
      mismatches   = 0;
      writes_seen  = 0;
      lvds_cmds    = 0;
      chan_cmds    = 0;
      test_cmds    = 0;
      dropped_cmds = 0;
    endfunction

    // Mirror one register write; only the register's own low bits are kept.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DRIVE: shadow.drive_currents = val[8:0];
        CFG_TERM:  shadow.terminations   = val[8:0];
        CFG_ADV:   shadow.advance_delay  = val[1:0];
        CFG_PHASE: shadow.lvds_phase_sel = val[1:0];
        CFG_CHAN:  shadow.channel_inputs = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return writes_due.size();
    endfunction

    // Three 3-bit codes placed one per nibble, lowest code in bits 2:0.
    function logic [15:0] spread(logic [8:0] v);
      return {5'd0, v[8:6], 1'b0, v[5:3], 1'b0, v[2:0]};
    endfunction

    // A selection with more than one bit set goes out as zero.
    function logic [3:0] sel_or_zero(logic [3:0] n);
      return ($countones(n) > 1) ? 4'd0 : n;
    endfunction

    function void push(logic [7:0] addr, logic [15:0] data, logic last);
      wr_t w;
      w.addr = addr;
      w.data = data;
      w.last = last;
      writes_due.push_back(w);
    endfunction

    // Work out the run of writes that one accepted command item causes.
    function void note_cmd(cmd_t c);
      logic [15:0] word;
      logic [15:0] ch;
      logic [15:0] r25, r26, r27, r45;
      ch = shadow.channel_inputs;
      case (c.req_type)
        REQ_LVDS: begin
          lvds_cmds++;
          push(ADDR_DRIVE, spread(shadow.drive_currents ^ DRIVE_FLIP), 1'b0);
          word = spread(shadow.terminations);
          if (shadow.terminations != '0) word[14] = 1'b1;
          push(ADDR_TERM, word, 1'b0);
          case (shadow.advance_delay)
            AD_ADVANCE: word = DATA_AD_ADV;
            AD_DELAY:   word = DATA_AD_DLY;
            default:    word = '0;
          endcase
          push(ADDR_ADV, word, 1'b0);
          push(ADDR_PHASE, {9'd0, shadow.lvds_phase_sel, 5'd0}, 1'b1);
        end
        REQ_CHAN: begin
          chan_cmds++;
          push(ADDR_CHAN_A, {3'd0, sel_or_zero(ch[7:4]), 4'd0, sel_or_zero(ch[3:0]), 1'b0},
               1'b0);
          push(ADDR_CHAN_B, {3'd0, sel_or_zero(ch[15:12]), 4'd0, sel_or_zero(ch[11:8]), 1'b0},
               1'b1);
        end
        REQ_TEST: begin
          test_cmds++;
          r25 = '0;
          r26 = '0;
          r27 = '0;
          r45 = '0;
          // Unknown selections fall through to off: all four words zero.
          case (c.test_sel)
            TS_COUNTER: r25 = DATA_COUNTER;
            TS_ALT: begin
              r25 = DATA_ALT;
              r26 = {c.test_word[15:8], 8'd0};
              r27 = {c.test_word[7:0], 8'd0};
            end
            TS_SINGLE: begin
              r25 = DATA_SINGLE;
              r26 = {c.test_word[7:0], 8'd0};
            end
            TS_DESKEW: r45 = DATA_DESKEW;
            TS_SYNC:   r45 = DATA_SYNC;
            default: ;
          endcase
          push(ADDR_TEST_25, r25, 1'b0);
          push(ADDR_TEST_26, r26, 1'b0);
          push(ADDR_TEST_27, r27, 1'b0);
          push(ADDR_TEST_45, r45, 1'b1);
        end
        default: dropped_cmds++;
      endcase
    endfunction

    // Compare one accepted write with the oldest one still due.
    task check_write(wr_t got);
      wr_t want;
      writes_seen++;
      if (writes_due.size() == 0) begin
        report($sformatf("write %0d: addr %h data %h last %b arrived with none due",
                         writes_seen, got.addr, got.data, got.last));
        return;
      end
      want = writes_due.pop_front();
      if (got.addr !== want.addr || got.data !== want.data || got.last !== want.last) begin
        report($sformatf("write %0d: got addr %h data %h last %b, wanted %h %h %b",
                         writes_seen, got.addr, got.data, got.last,
                         want.addr, want.data, want.last));
      end
    endtask

    task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("MISMATCH %s", msg);
    endtask
  endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench of the ADC configuration write sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acws_pkg::*;
  import acws_tb_pkg::*;

  localparam int CLK_PERIOD = 2;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_TAIL   = 8;
  localparam int unsigned BLOCK_ITEMS  = 57;
  localparam int unsigned NUM_BLOCKS   = 8;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [1:0]            req_type   = '0;
  logic [2:0]            test_sel   = '0;
  logic [15:0]           test_word  = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [7:0]            reg_addr;
  logic [15:0]           reg_data;
  logic                  last_write;
  logic                  wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index   = '0;
  logic [CFG_DATA_W-1:0] wr_data    = '0;

  int unsigned     sender_idle_pct = 0;
  int unsigned     stall_pct       = 0;
  int unsigned     hold_left       = 0;
  int unsigned     stuck_cycles    = 0;
  int unsigned     settings_used   = 1;
  write_scoreboard writes_sb;

  always #(CLK_PERIOD / 2) clk = ~clk;

  adc_config_write_sequencer_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .test_sel   (test_sel),
    .test_word  (test_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .last_write (last_write),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  // Write side: random stalls, or a long hold-off when one has been asked for.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Note each accepted command item and check each accepted write.
  always @(posedge clk) begin : item_monitor
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        writes_sb.note_cmd(cmd_t'{req_type, test_sel, test_word});
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        writes_sb.check_write(wr_t'{reg_addr, reg_data, last_write});
        moved = 1'b1;
      end
    end
    stuck_cycles <= moved ? 0 : stuck_cycles + 1;
  end

  // Give up when nothing has moved on either channel for too long.
  initial begin : watchdog
    do @(posedge clk); while (stuck_cycles < STUCK_LIMIT);
    $display("Timeout after %0d idle cycles with %0d writes still due",
             stuck_cycles, writes_sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one command item, after a random idle spell, and wait until it is taken.
  task send_cmd(input cmd_t c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= c.req_type;
    test_sel  <= c.test_sel;
    test_word <= c.test_word;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering items until every predicted write has come out.
  task wait_all_written(input int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    writes_sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Write one spare index, then every register, with random junk above each narrow register's bits.
  task apply_settings(input cfg_t s);
    write_reg(CFG_SPARE_FIRST + 3'($urandom_range(0, 2)), 16'($urandom));
    write_reg(CFG_DRIVE, {7'($urandom), s.drive_currents});
    write_reg(CFG_TERM,  {7'($urandom), s.terminations});
    write_reg(CFG_ADV,   {14'($urandom), s.advance_delay});
    write_reg(CFG_PHASE, {14'($urandom), s.lvds_phase_sel});
    write_reg(CFG_CHAN,  s.channel_inputs);
    wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [8:0] rand_triplets();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return 9'($urandom);
    endcase
  endfunction

  // Mostly one-hot selections so the channel words carry real content.
  function automatic cfg_t rand_settings();
    cfg_t s;
    s.drive_currents = rand_triplets();
    s.terminations   = rand_triplets();
    s.advance_delay  = 2'($urandom);
    s.lvds_phase_sel = 2'($urandom);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 3))
        0, 1:    s.channel_inputs[4*k +: 4] = 4'b0001 << $urandom_range(0, 3);
        2:       s.channel_inputs[4*k +: 4] = 4'b0000;
        default: s.channel_inputs[4*k +: 4] = 4'($urandom);
      endcase
    end
    return s;
  endfunction

  // Random command item, with a few of unknown type mixed in.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       c.req_type = REQ_NONE;
    else if (pick < 38) c.req_type = REQ_LVDS;
    else if (pick < 62) c.req_type = REQ_CHAN;
    else                c.req_type = REQ_TEST;
    c.test_sel = 3'($urandom);
    case ($urandom_range(0, 7))
      0:       c.test_word = 16'hffff;
      1:       c.test_word = 16'h0000;
      default: c.test_word = 16'($urandom);
    endcase
    return c;
  endfunction

  // One block of random items under one idling pattern.
  task run_block(input int unsigned idle, input int unsigned stall,
                 input bit hold_off, input bit mid_pause);
    cmd_t        c;
    int unsigned counted;
    sender_idle_pct = idle;
    stall_pct       = stall;
    if (hold_off) hold_left <= HOLD_CYCLES;
    counted = 0;
    while (counted < BLOCK_ITEMS) begin
      c = random_cmd();
      send_cmd(c);
      counted++;
      if (mid_pause && counted == BLOCK_ITEMS / 2) wait_all_written(0);
    end
    wait_all_written(DRAIN_TAIL);
  endtask

  initial begin
    writes_sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: every request type and test selection under the reset settings.
    send_cmd(cmd_t'{REQ_LVDS, TS_OFF, 16'h0000});
    send_cmd(cmd_t'{REQ_CHAN, TS_OFF, 16'hffff});
    for (int k = 0; k < 8; k++) send_cmd(cmd_t'{REQ_TEST, 3'(k), 16'hA5C3});
    send_cmd(cmd_t'{REQ_TEST, TS_ALT, 16'hffff});
    send_cmd(cmd_t'{REQ_TEST, TS_SINGLE, 16'hffff});
    send_cmd(cmd_t'{REQ_NONE, TS_SYNC, 16'hffff});
    wait_all_written(DRAIN_TAIL);

    // All registers at their top: every channel selection has several bits set.
    apply_settings(cfg_t'{9'h1ff, 9'h1ff, AD_ADVANCE, 2'd3, 16'hffff});
    send_cmd(cmd_t'{REQ_LVDS, TS_OFF, 16'h0000});
    send_cmd(cmd_t'{REQ_CHAN, TS_OFF, 16'h0000});
    wait_all_written(DRAIN_TAIL);

    // All registers at the bottom, with delay selected.
    apply_settings(cfg_t'{9'h000, 9'h000, AD_DELAY, 2'd0, 16'h0000});
    send_cmd(cmd_t'{REQ_LVDS, TS_OFF, 16'h0000});
    send_cmd(cmd_t'{REQ_CHAN, TS_OFF, 16'h0000});
    wait_all_written(DRAIN_TAIL);

    // The reserved advance/delay pattern, one termination set, distinct one-hot inputs.
    apply_settings(cfg_t'{9'o123, 9'o400, AD_RESERVED, 2'd2, 16'h1248});
    send_cmd(cmd_t'{REQ_LVDS, TS_OFF, 16'h0000});
    send_cmd(cmd_t'{REQ_CHAN, TS_OFF, 16'h0000});
    wait_all_written(DRAIN_TAIL);

    // Random blocks: no idling, sender idle, receiver stalling, then both; one adds a hold-off, one a mid-pause.
    for (int unsigned b = 0; b < NUM_BLOCKS; b++) begin
      apply_settings(rand_settings());
      case (b % 4)
        0:       run_block(0, 0, b == 4, 1'b0);
        1:       run_block(66, 0, 1'b0, 1'b0);
        2:       run_block(0, 66, 1'b0, b == 6);
        default: run_block(36, 36, 1'b0, 1'b0);
      endcase
    end

    wait_all_written(DRAIN_TAIL);
    $display("Covered %0d LVDS, %0d channel sync, %0d test mode and %0d unknown commands",
             writes_sb.lvds_cmds, writes_sb.chan_cmds, writes_sb.test_cmds,
             writes_sb.dropped_cmds);
    $display("over %0d register settings; %0d writes checked, %0d mismatches",
             settings_used, writes_sb.writes_seen, writes_sb.mismatches);
    if (writes_sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/acws_pkg.sv
rtl/core/acws_cfg_regs.sv
rtl/core/acws_word_gen.sv
rtl/core/adc_config_write_sequencer_top.sv
dv/acws_tb_pkg.sv
dv/tb_top.sv
